>>> rtl/lpc_pkg.sv
// Lattice path count: shared types, constants and the modular add.
// No dependencies; every other file of the block imports this package.
package lpc_pkg;

  localparam int unsigned MAX_COORD = 511;
  localparam int unsigned COORD_W   = 9;
  localparam int unsigned COUNT_W   = 30;
  localparam int unsigned NUM_CELLS = MAX_COORD;
  localparam int unsigned CNT_W     = $clog2(2 * MAX_COORD + 2);
  localparam int unsigned IN_DATA_W  = 24;
  localparam int unsigned OUT_DATA_W = 32;

  localparam logic [COUNT_W-1:0] PATH_MODULUS = COUNT_W'(1000000007);
  localparam logic [COUNT_W-1:0] COUNT_ONE    = COUNT_W'(1);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CLEAR,
    ST_RUN,
    ST_SHIFT,
    ST_OUT
  } lpc_state_e;

  typedef struct packed {
    logic clr;
    logic shift;
    logic feed;
  } chain_ctrl_t;

  function automatic logic [COUNT_W-1:0] add_mod(input logic [COUNT_W-1:0] a,
                                                 input logic [COUNT_W-1:0] b);
    logic [COUNT_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s >= {1'b0, PATH_MODULUS}) begin
      s = s - {1'b0, PATH_MODULUS};
    end
    return s[COUNT_W-1:0];
  endfunction

  function automatic logic [COORD_W-1:0] clamp_coord(input logic [COORD_W-1:0] raw);
    logic [COORD_W:0] lim;
    lim = (COORD_W + 1)'(MAX_COORD);
    if ({1'b0, raw} > lim) begin
      return lim[COORD_W-1:0];
    end
    return raw;
  endfunction

endpackage

>>> rtl/lattice_path_count_mod.sv
// Lattice path count modulo 1e9+7: top level with stream ports, sequencer and cell chain.
// Depends on lpc_pkg, lpc_cell and lpc_ctrl.
//
//   channel   dir  beat content
//   s_axis    in   tdata: x_coord[8:0], y_coord[17:9], zero pad to 24 bits
//   m_axis    out  tdata: path_count[29:0], zero pad to 32 bits
//
// Each beat runs from accept to result through a clear, the diagonal wavefront
// through the cell chain, a shift of cell y - 1 to the tail with settling, and
// a load. The next beat is taken once the sequencer is idle again; input is held
// off meanwhile. The load stalls while the output register still holds an
// unaccepted result; a finished result waits there while the next beat runs.
// Reset (rst_ni low, async) idles the sequencer and empties the output register.
module lattice_path_count_mod (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  input  logic [lpc_pkg::IN_DATA_W-1:0]   s_axis_tdata,   // x_coord, y_coord, pad
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  output logic [lpc_pkg::OUT_DATA_W-1:0]  m_axis_tdata    // path_count, pad
);
  import lpc_pkg::*;

  chain_ctrl_t        ctrl;
  logic [COUNT_W-1:0] cell_value [NUM_CELLS];
  logic               cell_en    [NUM_CELLS];
  logic [COUNT_W-1:0] path_count;

  lpc_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (s_axis_tvalid),
    .in_ready_o   (s_axis_tready),
    .x_coord_i    (s_axis_tdata[COORD_W-1:0]),
    .y_coord_i    (s_axis_tdata[2*COORD_W-1:COORD_W]),
    .tail_i       (cell_value[NUM_CELLS-1]),
    .ctrl_o       (ctrl),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .path_count_o (path_count)
  );

  for (genvar g = 0; g < NUM_CELLS; g++) begin : g_cell
    if (g == 0) begin : g_head
      lpc_cell u_cell (
        .clk_i   (clk_i),
        .rst_ni  (rst_ni),
        .ctrl_i  (ctrl),
        .en_i    (ctrl.feed),
        .left_i  (COUNT_ONE),
        .en_o    (cell_en[g]),
        .value_o (cell_value[g])
      );
    end else begin : g_body
      lpc_cell u_cell (
        .clk_i   (clk_i),
        .rst_ni  (rst_ni),
        .ctrl_i  (ctrl),
        .en_i    (cell_en[g-1]),
        .left_i  (cell_value[g-1]),
        .en_o    (cell_en[g]),
        .value_o (cell_value[g])
      );
    end
  end

  assign m_axis_tdata = {{(OUT_DATA_W - COUNT_W){1'b0}}, path_count};

endmodule

>>> rtl/lpc_cell.sv
// Lattice path count: one row store cell of the systolic chain.
// Depends on lpc_pkg for widths, the control struct and add_mod.
module lpc_cell (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  lpc_pkg::chain_ctrl_t        ctrl_i,
  input  logic                        en_i,
  input  logic [lpc_pkg::COUNT_W-1:0] left_i,
  output logic                        en_o,
  output logic [lpc_pkg::COUNT_W-1:0] value_o
);
  import lpc_pkg::*;

  logic               en_q, en_d;
  logic [COUNT_W-1:0] value_q, value_d;

  always_comb begin
    en_d    = en_i;
    value_d = value_q;
    if (ctrl_i.clr) begin
      en_d    = 1'b0;
      value_d = '0;
    end else if (ctrl_i.shift) begin
      en_d    = 1'b0;
      value_d = left_i;
    end else if (en_i) begin
      value_d = add_mod(value_q, left_i);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      en_q <= 1'b0;
    end else begin
      en_q <= en_d;
    end
  end

  always_ff @(posedge clk_i) begin
    value_q <= value_d;
  end

  assign en_o    = en_q;
  assign value_o = value_q;

endmodule

>>> rtl/lpc_ctrl.sv
// Lattice path count: sequencer for clear, wavefront run, unload shift and output beat.
// Depends on lpc_pkg for the state enum, chain control struct and constants.
module lpc_ctrl (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [lpc_pkg::COORD_W-1:0]   x_coord_i,
  input  logic [lpc_pkg::COORD_W-1:0]   y_coord_i,
  input  logic [lpc_pkg::COUNT_W-1:0]   tail_i,
  output lpc_pkg::chain_ctrl_t          ctrl_o,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [lpc_pkg::COUNT_W-1:0]   path_count_o
);
  import lpc_pkg::*;

  lpc_state_e         state_q, state_d;
  logic [CNT_W-1:0]   cnt_q, cnt_d;
  logic [COORD_W-1:0] xs_q, xs_d;
  logic [COORD_W-1:0] ys_q, ys_d;
  logic               out_valid_q, out_valid_d;
  logic [COUNT_W-1:0] out_data_q, out_data_d;

  logic [CNT_W-1:0]   run_last;
  logic [COORD_W-1:0] shift_rem;
  logic               accept;
  logic               load;

  assign run_last  = CNT_W'(xs_q) + CNT_W'(ys_q);
  assign shift_rem = COORD_W'(NUM_CELLS) - ys_q;
  assign accept    = in_valid_i && (state_q == ST_IDLE);
  assign load      = (state_q == ST_OUT) && (!out_valid_q || out_ready_i);

  always_comb begin
    state_d      = state_q;
    cnt_d        = cnt_q;
    xs_d         = xs_q;
    ys_d         = ys_q;
    out_valid_d  = out_valid_q;
    out_data_d   = out_data_q;
    ctrl_o       = '0;
    in_ready_o   = 1'b0;

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          xs_d    = clamp_coord(x_coord_i);
          ys_d    = clamp_coord(y_coord_i);
          state_d = ST_CLEAR;
        end
      end
      ST_CLEAR: begin
        ctrl_o.clr = 1'b1;
        cnt_d      = '0;
        state_d    = ST_RUN;
      end
      ST_RUN: begin
        ctrl_o.feed = (cnt_q <= CNT_W'(xs_q));
        if (cnt_q == run_last) begin
          cnt_d   = '0;
          state_d = ST_SHIFT;
        end else begin
          cnt_d = cnt_q + CNT_W'(1);
        end
      end
      ST_SHIFT: begin
        if (cnt_q == CNT_W'(shift_rem)) begin
          state_d = ST_OUT;
        end else begin
          ctrl_o.shift = 1'b1;
          cnt_d        = cnt_q + CNT_W'(1);
        end
      end
      ST_OUT: begin
        if (load) begin
          out_valid_d = 1'b1;
          out_data_d  = (ys_q == '0) ? COUNT_ONE : tail_i;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    xs_q       <= xs_d;
    ys_q       <= ys_d;
    out_data_q <= out_data_d;
  end

  assign out_valid_o  = out_valid_q;
  assign path_count_o = out_data_q;

  a_accept_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> (state_q == ST_CLEAR))
    else $error("accepted beat did not start a clear");

  a_run_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_RUN) |-> (cnt_q <= run_last))
    else $error("run counter passed the wavefront end");

  a_run_to_shift: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == ST_RUN) && (cnt_q == run_last)) |=> (state_q == ST_SHIFT))
    else $error("run did not hand over to unload shift");

  a_shift_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SHIFT) |-> (cnt_q <= CNT_W'(shift_rem)))
    else $error("unload shift ran too far");

  a_load_sets_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load |=> (out_valid_q && (state_q == ST_IDLE)))
    else $error("result load lost");

endmodule
